// ===== hw/rtl/terrain_lod_delta_interval_core_macros.svh =====
// assertion helpers for the top-level core
`ifndef TERRAIN_LOD_DELTA_INTERVAL_CORE_MACROS_SVH
`define TERRAIN_LOD_DELTA_INTERVAL_CORE_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define TLDI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define TLDI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tldi_pkg.sv =====
`default_nettype none

package tldi_pkg;

    // stride saturation point
    localparam int MAX_STRIDE = 128;

    // operand and result widths of the threshold units
    localparam int DEN_W = 66;
    localparam int DVS_W = 65;
    localparam int SQ_W  = 132;
    localparam int NUM_W = 148;
    localparam int Q_W   = 64;

    // configuration register file
    typedef struct packed {
        logic        assume_close;
        logic [31:0] tolerance;
        logic [31:0] eye_x;
        logic [31:0] eye_y;
        logic [31:0] eye_z;
        logic [17:0] view_dir_x;
        logic [17:0] view_dir_y;
        logic [31:0] grid_spacing;
    } cfg_t;

    // one terrain block
    typedef struct packed {
        logic [31:0] box_min_x;
        logic [31:0] box_min_y;
        logic [31:0] box_min_z;
        logic [31:0] box_max_x;
        logic [31:0] box_max_y;
        logic [31:0] box_max_z;
        logic [31:0] block_loc_x;
        logic [31:0] block_loc_y;
        logic [7:0]  block_stride;
    } geom_t;

    // operands of one threshold unit: floor(tol * S / (dvs * 2^16))
    // with S = den^2 when sq is set, else S = den
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DVS_W-1:0] dvs;
        logic             sq;
    } delta_op_t;

    // state of one restoring divide step
    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [Q_W-1:0]   n;
        logic [Q_W-1:0]   q;
        logic [DVS_W-1:0] dvs;
        logic             force0;
        logic             sat;
    } div_t;

    // sign-extended difference of two signed 32 bit values
    function automatic logic signed [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
        sdiff = $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    // magnitude of a 33 bit signed difference, always below 2^32
    function automatic logic [31:0] mag33(input logic signed [32:0] d);
        logic [32:0] m;
        m = d[32] ? 33'(-d) : 33'(d);
        mag33 = m[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tldi_front.sv =====
`default_nettype none

module tldi_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      in_vld,
    input  wire tldi_pkg::geom_t           in_geom,
    input  wire tldi_pkg::cfg_t            cfg,
    output logic                           out_vld,
    output tldi_pkg::delta_op_t [2:0]      out_op
);
    import tldi_pkg::*;

    // valid chain of the six geometry stages
    logic [5:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    assign out_vld = vld_reg[5];

    // stage 1: capture the block
    geom_t g1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg <= in_geom;
        end
    end

    // stage 2: eye differences, axis side flags, block offsets from the eye, block half-size
    logic signed [32:0] dxn_next, dxx_next, dyn_next, dyx_next, dzn_next, dzx_next;
    logic signed [32:0] dxn_reg, dxx_reg, dyn_reg, dyx_reg, dzn_reg, dzx_reg;
    logic signed [32:0] lx_next, ly_next, lx_reg, ly_reg;
    logic [7:0]         stride_sat;
    logic [39:0]        half_next, half_reg;
    logic [5:0]         flag_next, flag2_reg, flag3_reg;

    always_comb begin
        dxn_next = sdiff(cfg.eye_x, g1_reg.box_min_x);
        dxx_next = sdiff(cfg.eye_x, g1_reg.box_max_x);
        dyn_next = sdiff(cfg.eye_y, g1_reg.box_min_y);
        dyx_next = sdiff(cfg.eye_y, g1_reg.box_max_y);
        dzn_next = sdiff(cfg.eye_z, g1_reg.box_min_z);
        dzx_next = sdiff(cfg.eye_z, g1_reg.box_max_z);
        // x below, x not above, y below, y not above, z below, z above
        flag_next[0] = $signed(cfg.eye_x) <  $signed(g1_reg.box_min_x);
        flag_next[1] = $signed(cfg.eye_x) <= $signed(g1_reg.box_max_x);
        flag_next[2] = $signed(cfg.eye_y) <  $signed(g1_reg.box_min_y);
        flag_next[3] = $signed(cfg.eye_y) <= $signed(g1_reg.box_max_y);
        flag_next[4] = $signed(cfg.eye_z) <  $signed(g1_reg.box_min_z);
        flag_next[5] = $signed(cfg.eye_z) >  $signed(g1_reg.box_max_z);
        lx_next = sdiff(g1_reg.block_loc_x, cfg.eye_x);
        ly_next = sdiff(g1_reg.block_loc_y, cfg.eye_y);
        stride_sat = (g1_reg.block_stride > 8'(MAX_STRIDE)) ? 8'(MAX_STRIDE)
                                                             : g1_reg.block_stride;
        half_next = cfg.grid_spacing * stride_sat;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxn_reg   <= dxn_next;
            dxx_reg   <= dxx_next;
            dyn_reg   <= dyn_next;
            dyx_reg   <= dyx_next;
            dzn_reg   <= dzn_next;
            dzx_reg   <= dzx_next;
            flag2_reg <= flag_next;
            lx_reg    <= lx_next;
            ly_reg    <= ly_next;
            half_reg  <= half_next;
        end
    end

    // stage 3: squared distances, corner offsets
    logic [31:0]        m_xn, m_xx, m_yn, m_yx, m_zn, m_zx;
    logic [63:0]        sxn_next, sxx_next, syn_next, syx_next, szn_next, szx_next;
    logic [63:0]        sxn_reg, sxx_reg, syn_reg, syx_reg, szn_reg, szx_reg;
    logic signed [40:0] xs_next, xd_next, ys_next, yd_next;
    logic signed [40:0] xs_reg, xd_reg, ys_reg, yd_reg;
    logic signed [40:0] lx41, ly41, half41;

    always_comb begin
        m_xn = mag33(dxn_reg);
        m_xx = mag33(dxx_reg);
        m_yn = mag33(dyn_reg);
        m_yx = mag33(dyx_reg);
        m_zn = mag33(dzn_reg);
        m_zx = mag33(dzx_reg);
        sxn_next = m_xn * m_xn;
        sxx_next = m_xx * m_xx;
        syn_next = m_yn * m_yn;
        syx_next = m_yx * m_yx;
        szn_next = m_zn * m_zn;
        szx_next = m_zx * m_zx;
        lx41   = 41'(lx_reg);
        ly41   = 41'(ly_reg);
        half41 = $signed({1'b0, half_reg});
        xs_next = lx41 + half41;
        xd_next = lx41 - half41;
        ys_next = ly41 + half41;
        yd_next = ly41 - half41;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sxn_reg   <= sxn_next;
            sxx_reg   <= sxx_next;
            syn_reg   <= syn_next;
            syx_reg   <= syx_next;
            szn_reg   <= szn_next;
            szx_reg   <= szx_next;
            flag3_reg <= flag2_reg;
            xs_reg    <= xs_next;
            xd_reg    <= xd_next;
            ys_reg    <= ys_next;
            yd_reg    <= yd_next;
        end
    end

    // stage 4: height and plane distance bounds, view direction products
    logic [63:0]        hmin_next, hmax_next, hmin_reg, hmax_reg;
    logic [63:0]        rminx, rmaxx, rminy, rmaxy;
    logic [64:0]        rmin_next, rmax_next, rmin_reg, rmax_reg;
    logic signed [17:0] vdx, vdy;
    logic signed [58:0] pxd_next, pxs_next, pyd_next, pys_next;
    logic signed [58:0] pxd_reg, pxs_reg, pyd_reg, pys_reg;

    always_comb begin
        if (flag3_reg[4]) begin
            hmin_next = szn_reg;
        end else if (flag3_reg[5]) begin
            hmin_next = szx_reg;
        end else begin
            hmin_next = '0;
        end
        hmax_next = (szx_reg > szn_reg) ? szx_reg : szn_reg;

        // x axis
        if (flag3_reg[0]) begin
            rminx = sxn_reg;
            rmaxx = sxx_reg;
        end else if (flag3_reg[1]) begin
            rminx = '0;
            rmaxx = (sxx_reg >= sxn_reg) ? sxx_reg : sxn_reg;
        end else begin
            rminx = sxx_reg;
            rmaxx = sxn_reg;
        end
        // y axis
        if (flag3_reg[2]) begin
            rminy = syn_reg;
            rmaxy = syx_reg;
        end else if (flag3_reg[3]) begin
            rminy = '0;
            rmaxy = (syx_reg >= syn_reg) ? syx_reg : syn_reg;
        end else begin
            rminy = syx_reg;
            rmaxy = syn_reg;
        end
        rmin_next = 65'(rminx) + 65'(rminy);
        rmax_next = 65'(rmaxx) + 65'(rmaxy);

        vdx = $signed(cfg.view_dir_x);
        vdy = $signed(cfg.view_dir_y);
        pxd_next = vdx * xd_reg;
        pxs_next = vdx * xs_reg;
        pyd_next = vdy * yd_reg;
        pys_next = vdy * ys_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hmin_reg <= hmin_next;
            hmax_reg <= hmax_next;
            rmin_reg <= rmin_next;
            rmax_reg <= rmax_next;
            pxd_reg  <= pxd_next;
            pxs_reg  <= pxs_next;
            pyd_reg  <= pyd_next;
            pys_reg  <= pys_next;
        end
    end

    // stage 5: distant operands, close corner magnitudes
    delta_op_t [2:0]    dop_next, dop_reg;
    logic signed [59:0] c_sum [4];
    logic [59:0]        cv_next [4];
    logic [59:0]        cv_reg [4];
    logic [64:0]        hmin65;

    always_comb begin
        hmin65 = 65'(hmin_reg);
        dop_next[0].den = 66'(rmin_reg) + 66'(hmax_reg);
        dop_next[0].dvs = rmin_reg;
        dop_next[0].sq  = 1'b1;
        dop_next[1].den = 66'(rmax_reg) + 66'(hmax_reg);
        dop_next[1].dvs = rmax_reg;
        dop_next[1].sq  = 1'b1;
        if (rmin_reg >= hmin65) begin
            dop_next[2].den = 66'(rmin_reg) + 66'(hmin_reg);
            dop_next[2].dvs = rmin_reg;
            dop_next[2].sq  = 1'b1;
        end else if (rmax_reg <= hmin65) begin
            dop_next[2].den = 66'(rmax_reg) + 66'(hmin_reg);
            dop_next[2].dvs = rmax_reg;
            dop_next[2].sq  = 1'b1;
        end else begin
            // hmin strictly between rmin and rmax: four times hmin over one
            dop_next[2].den = {hmin_reg, 2'b00};
            dop_next[2].dvs = 65'd1;
            dop_next[2].sq  = 1'b0;
        end

        c_sum[0] = 60'(pxd_reg) + 60'(pyd_reg);
        c_sum[1] = 60'(pxs_reg) + 60'(pyd_reg);
        c_sum[2] = 60'(pxs_reg) + 60'(pys_reg);
        c_sum[3] = 60'(pxd_reg) + 60'(pys_reg);
        for (int i = 0; i < 4; i++) begin
            cv_next[i] = c_sum[i][59] ? 60'(-c_sum[i]) : 60'(c_sum[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dop_reg <= dop_next;
            cv_reg  <= cv_next;
        end
    end

    // stage 6: close corner running choice, mode select
    logic [59:0]     run_hi, run_lo;
    delta_op_t [2:0] op_next, op_reg;

    always_comb begin
        // first corner sets both; a later corner at or above the running
        // high replaces it, otherwise it replaces the low one
        run_hi = cv_reg[0];
        run_lo = cv_reg[0];
        for (int i = 1; i < 4; i++) begin
            if (cv_reg[i] >= run_hi) begin
                run_hi = cv_reg[i];
            end else begin
                run_lo = cv_reg[i];
            end
        end

        if (cfg.assume_close) begin
            op_next[0].den = 66'(run_hi);
            op_next[0].dvs = 65'd1;
            op_next[0].sq  = 1'b0;
            op_next[1]     = op_next[0];
            op_next[2].den = 66'(run_lo);
            op_next[2].dvs = 65'd1;
            op_next[2].sq  = 1'b0;
        end else begin
            op_next = dop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg <= op_next;
        end
    end

    assign out_op = op_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tldi_div_step.sv =====
`default_nettype none

module tldi_div_step (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           adv,
    input  wire logic           in_vld,
    input  wire tldi_pkg::div_t in_d,
    output logic                out_vld,
    output tldi_pkg::div_t      out_d
);
    import tldi_pkg::*;

    logic             vld_reg;
    div_t             d_next, d_reg;
    logic [DVS_W:0]   trial, diff;
    logic             ge;

    // one restoring quotient bit
    always_comb begin
        trial = {in_d.rem, in_d.n[Q_W-1]};
        diff  = trial - {1'b0, in_d.dvs};
        ge    = trial >= {1'b0, in_d.dvs};
        d_next        = in_d;
        d_next.rem    = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        d_next.n      = {in_d.n[Q_W-2:0], 1'b0};
        d_next.q      = {in_d.q[Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg <= d_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_d   = d_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tldi_delta_unit.sv =====
`default_nettype none

module tldi_delta_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                adv,
    input  wire logic                in_vld,
    input  wire tldi_pkg::delta_op_t in_op,
    input  wire logic [31:0]         tol,
    output logic                     out_vld,
    output logic [63:0]              out_q
);
    import tldi_pkg::*;

    // valid chain of the five setup stages
    logic [4:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    // stage a: partial products of den squared
    logic [32:0]      a_hi, a_lo;
    logic [65:0]      p2_reg, p1_reg, p0_reg;
    logic [DEN_W-1:0] den_a_reg;
    logic [DVS_W-1:0] dvs_a_reg;
    logic             sq_a_reg;

    assign a_hi = in_op.den[65:33];
    assign a_lo = in_op.den[32:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg    <= a_hi * a_hi;
            p1_reg    <= a_hi * a_lo;
            p0_reg    <= a_lo * a_lo;
            den_a_reg <= in_op.den;
            dvs_a_reg <= in_op.dvs;
            sq_a_reg  <= in_op.sq;
        end
    end

    // stage b: sum up the numerator factor
    logic [SQ_W-1:0]  s_next, s_reg;
    logic [DVS_W-1:0] dvs_b_reg;
    logic             szero_b_reg;

    always_comb begin
        if (sq_a_reg) begin
            s_next = (SQ_W'(p2_reg) << 66) + (SQ_W'(p1_reg) << 34) + SQ_W'(p0_reg);
        end else begin
            s_next = SQ_W'(den_a_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_reg       <= s_next;
            dvs_b_reg   <= dvs_a_reg;
            szero_b_reg <= (s_next == '0);
        end
    end

    // stage c: tolerance times each 33 bit limb
    logic [64:0]      t_reg [4];
    logic [DVS_W-1:0] dvs_c_reg;
    logic             szero_c_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg[0]    <= tol * s_reg[32:0];
            t_reg[1]    <= tol * s_reg[65:33];
            t_reg[2]    <= tol * s_reg[98:66];
            t_reg[3]    <= tol * s_reg[131:99];
            dvs_c_reg   <= dvs_b_reg;
            szero_c_reg <= szero_b_reg;
        end
    end

    // stage d: full product, dropped by the 2^16 scale of the divisor
    logic [163:0]     prod;
    logic [NUM_W-1:0] num_reg;
    logic [DVS_W-1:0] dvs_d_reg;
    logic             szero_d_reg;

    assign prod = 164'(t_reg[0]) + (164'(t_reg[1]) << 33)
                + (164'(t_reg[2]) << 66) + (164'(t_reg[3]) << 99);

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg     <= prod[163:16];
            dvs_d_reg   <= dvs_c_reg;
            szero_d_reg <= szero_c_reg;
        end
    end

    // stage e: overflow and zero divisor check, divider seed
    logic [83:0] num_top;
    logic        dvs_zero;
    div_t        seed_next, seed_reg;

    always_comb begin
        num_top  = num_reg[NUM_W-1:Q_W];
        dvs_zero = (dvs_d_reg == '0);
        seed_next.rem    = num_top[DVS_W-1:0];
        seed_next.n      = num_reg[Q_W-1:0];
        seed_next.q      = '0;
        seed_next.dvs    = dvs_d_reg;
        seed_next.force0 = dvs_zero && szero_d_reg;
        seed_next.sat    = dvs_zero ? !szero_d_reg : (num_top >= 84'(dvs_d_reg));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            seed_reg <= seed_next;
        end
    end

    // one register stage per quotient bit
    div_t       chain [Q_W+1];
    logic [Q_W:0] vchain;

    assign chain[0]  = seed_reg;
    assign vchain[0] = vld_reg[4];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        tldi_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .in_vld  (vchain[k]),
            .in_d    (chain[k]),
            .out_vld (vchain[k+1]),
            .out_d   (chain[k+1])
        );
    end

    // special results override the quotient
    always_comb begin
        if (chain[Q_W].force0) begin
            out_q = '0;
        end else if (chain[Q_W].sat) begin
            out_q = '1;
        end else begin
            out_q = chain[Q_W].q;
        end
    end

    assign out_vld = vchain[Q_W];

endmodule

`default_nettype wire

// ===== hw/rtl/terrain_lod_delta_interval_core.sv =====
// Level-of-detail delta interval for terrain quadtree blocks.
// Configure over the APB port (eight 32 bit registers at 4*i) while no
// block is in flight. Each block is one transfer on the s_ channel (box,
// centre, stride); each answer is one transfer on the m_ channel carrying
// delta_low and delta_high as unsigned Q32.32, all ones meaning infinity.
// One block can be taken every clock cycle while the output is not stalled.
// Each block passes six geometry stages, five setup stages that form the
// scaled numerator and divider seed, one register per quotient bit of the
// 64 stage restoring divider, and the output register. Three threshold
// units run side by side. When m_valid is high and the receiver holds
// m_ready low the whole pipeline freezes and s_ready drops in the same
// cycle, so nothing is lost or repeated. Synchronous active-low reset
// empties the pipeline and loads register defaults: distant mode, zero
// tolerance, eye and view direction zero, grid spacing 1.0.
`default_nettype none
`include "terrain_lod_delta_interval_core_macros.svh"

module terrain_lod_delta_interval_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // block input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_box_min_x,
    input  wire logic [31:0] s_box_min_y,
    input  wire logic [31:0] s_box_min_z,
    input  wire logic [31:0] s_box_max_x,
    input  wire logic [31:0] s_box_max_y,
    input  wire logic [31:0] s_box_max_z,
    input  wire logic [31:0] s_block_loc_x,
    input  wire logic [31:0] s_block_loc_y,
    input  wire logic [7:0]  s_block_stride,
    // thresholds
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_delta_low,
    output logic [63:0]      m_delta_high
);
    import tldi_pkg::*;

    localparam logic [2:0] REG_ASSUME_CLOSE = 3'd0;
    localparam logic [2:0] REG_TOLERANCE    = 3'd1;
    localparam logic [2:0] REG_EYE_X        = 3'd2;
    localparam logic [2:0] REG_EYE_Y        = 3'd3;
    localparam logic [2:0] REG_EYE_Z        = 3'd4;
    localparam logic [2:0] REG_VIEW_DIR_X   = 3'd5;
    localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd6;
    localparam logic [2:0] REG_GRID_SPACING = 3'd7;

    // register file write
    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.assume_close <= 1'b0;
            cfg_reg.tolerance    <= '0;
            cfg_reg.eye_x        <= '0;
            cfg_reg.eye_y        <= '0;
            cfg_reg.eye_z        <= '0;
            cfg_reg.view_dir_x   <= '0;
            cfg_reg.view_dir_y   <= '0;
            cfg_reg.grid_spacing <= 32'h0001_0000;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ASSUME_CLOSE: cfg_reg.assume_close <= pwdata[0];
                REG_TOLERANCE:    cfg_reg.tolerance    <= pwdata;
                REG_EYE_X:        cfg_reg.eye_x        <= pwdata;
                REG_EYE_Y:        cfg_reg.eye_y        <= pwdata;
                REG_EYE_Z:        cfg_reg.eye_z        <= pwdata;
                REG_VIEW_DIR_X:   cfg_reg.view_dir_x   <= pwdata[17:0];
                REG_VIEW_DIR_Y:   cfg_reg.view_dir_y   <= pwdata[17:0];
                REG_GRID_SPACING: cfg_reg.grid_spacing <= pwdata;
                default: ;
            endcase
        end
    end

    // register file read
    always_comb begin
        case (reg_idx)
            REG_ASSUME_CLOSE: prdata = {31'd0, cfg_reg.assume_close};
            REG_TOLERANCE:    prdata = cfg_reg.tolerance;
            REG_EYE_X:        prdata = cfg_reg.eye_x;
            REG_EYE_Y:        prdata = cfg_reg.eye_y;
            REG_EYE_Z:        prdata = cfg_reg.eye_z;
            REG_VIEW_DIR_X:   prdata = {14'd0, cfg_reg.view_dir_x};
            REG_VIEW_DIR_Y:   prdata = {14'd0, cfg_reg.view_dir_y};
            REG_GRID_SPACING: prdata = cfg_reg.grid_spacing;
            default:          prdata = '0;
        endcase
    end

    // pipeline advances whenever the output slot is free or being taken
    logic m_valid_reg;
    logic adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // geometry front end
    geom_t           geom;
    logic            f_vld;
    delta_op_t [2:0] f_op;

    assign geom.box_min_x    = s_box_min_x;
    assign geom.box_min_y    = s_box_min_y;
    assign geom.box_min_z    = s_box_min_z;
    assign geom.box_max_x    = s_box_max_x;
    assign geom.box_max_y    = s_box_max_y;
    assign geom.box_max_z    = s_box_max_z;
    assign geom.block_loc_x  = s_block_loc_x;
    assign geom.block_loc_y  = s_block_loc_y;
    assign geom.block_stride = s_block_stride;

    tldi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_valid),
        .in_geom (geom),
        .cfg     (cfg_reg),
        .out_vld (f_vld),
        .out_op  (f_op)
    );

    // threshold units: 0 and 1 feed delta_high, 2 feeds delta_low
    logic [2:0]  u_vld;
    logic [63:0] u_q [3];

    for (genvar u = 0; u < 3; u++) begin : g_unit
        tldi_delta_unit u_delta (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .in_vld  (f_vld),
            .in_op   (f_op[u]),
            .tol     (cfg_reg.tolerance),
            .out_vld (u_vld[u]),
            .out_q   (u_q[u])
        );
    end

    // output register
    logic [63:0] lo_next, hi_next, lo_reg, hi_reg;

    always_comb begin
        if (cfg_reg.tolerance == '0) begin
            lo_next = '0;
            hi_next = '1;
        end else begin
            lo_next = u_q[2];
            if (cfg_reg.assume_close || (u_q[0] > u_q[1])) begin
                hi_next = u_q[0];
            end else begin
                hi_next = u_q[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= u_vld[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_delta_low  = lo_reg;
    assign m_delta_high = hi_reg;

    // checks
    `TLDI_ASSERT_IMP(a_zero_tol, m_valid_reg && (cfg_reg.tolerance == '0), (lo_reg == '0) && (hi_reg == '1), "zero tolerance must give the trivial interval")
    `TLDI_ASSERT_IMP(a_unit_lockstep, u_vld[0] || u_vld[1] || u_vld[2], u_vld[0] && u_vld[1] && u_vld[2], "threshold units out of step")
    `TLDI_ASSERT_NXT(a_unit_to_out, u_vld[0] && adv, m_valid_reg, "finished item did not reach the output register")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tldi_pkg::*;

    typedef enum int {
        REG_ASSUME_CLOSE = 0,
        REG_TOLERANCE    = 1,
        REG_EYE_X        = 2,
        REG_EYE_Y        = 3,
        REG_EYE_Z        = 4,
        REG_VIEW_DIR_X   = 5,
        REG_VIEW_DIR_Y   = 6,
        REG_GRID_SPACING = 7
    } reg_index_e;

    typedef logic [255:0] wide_t;

    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 100;

    // threshold predictor and store of expected intervals
    class delta_scoreboard;
        bit        close_sel;
        bit [31:0] tol, eye_x, eye_y, eye_z, grid;
        bit [17:0] dir_x, dir_y;
        bit [63:0] exp_low[$];
        bit [63:0] exp_high[$];
        int        errors;
        int        checked;
        int        close_items;
        int        distant_items;

        function new();
            close_sel = 0; tol = 0; eye_x = 0; eye_y = 0; eye_z = 0;
            dir_x = 0; dir_y = 0; grid = 32'h0001_0000;
            errors = 0; checked = 0; close_items = 0; distant_items = 0;
        endfunction

        function void set_reg(reg_index_e idx, bit [31:0] v);
            case (idx)
                REG_ASSUME_CLOSE: close_sel = v[0];
                REG_TOLERANCE:    tol = v;
                REG_EYE_X:        eye_x = v;
                REG_EYE_Y:        eye_y = v;
                REG_EYE_Z:        eye_z = v;
                REG_VIEW_DIR_X:   dir_x = v[17:0];
                REG_VIEW_DIR_Y:   dir_y = v[17:0];
                REG_GRID_SPACING: grid = v;
                default: ;
            endcase
        endfunction

        // tolerance * num / (den * 2^16), saturating at Q32.32
        function bit [63:0] scale_tol(wide_t num, wide_t den);
            wide_t q;
            if (den == 0) return '1;
            q = (wide_t'(tol) * num) / (den << 16);
            if (q[255:64] != 0) return '1;
            return q[63:0];
        endfunction

        function bit [63:0] ratio_thresh(wide_t r, wide_t h);
            wide_t d;
            d = r + h;
            if (d == 0) return 64'd0;
            return scale_tol(d * d, r);
        endfunction

        // square of the magnitude in 64 bits, as the front end computes it
        function bit [63:0] sq64(longint d);
            bit [63:0] a;
            a = d < 0 ? 64'(-d) : 64'(d);
            return a * a;
        endfunction

        function void axis_dist(longint e, longint lo, longint hi,
                                inout wide_t rmin, inout wide_t rmax);
            bit [63:0] dlo, dhi;
            dlo = sq64(e - lo);
            dhi = sq64(e - hi);
            if (e < lo) begin
                rmin += dlo;
                rmax += dhi;
            end else if (e <= hi) begin
                rmax += (dhi >= dlo) ? dhi : dlo;
            end else begin
                rmin += dhi;
                rmax += dlo;
            end
        endfunction

        function void predict(geom_t g, output bit [63:0] lo, output bit [63:0] hi);
            longint    ex, ey, ez, nz, xz, lx, ly, half, xs, ys, xd, yd, ddx, ddy, s;
            bit [63:0] hmin_u, hmax_u, t, c1, c2, fmin, fmax;
            bit [63:0] v[4];
            wide_t     rmin, rmax, hmin;
            int        stride;
            ex = longint'($signed(eye_x));
            ey = longint'($signed(eye_y));
            ez = longint'($signed(eye_z));
            if (tol == 0) begin
                lo = 0;
                hi = '1;
            end else if (close_sel) begin
                close_items++;
                ddx = longint'($signed(dir_x));
                ddy = longint'($signed(dir_y));
                lx = longint'($signed(g.block_loc_x)) - ex;
                ly = longint'($signed(g.block_loc_y)) - ey;
                stride = g.block_stride > MAX_STRIDE ? MAX_STRIDE : g.block_stride;
                half = longint'({32'd0, grid}) * stride;
                xs = lx + half; ys = ly + half;
                xd = lx - half; yd = ly - half;
                s = ddx * xd + ddy * yd; v[0] = s < 0 ? 64'(-s) : 64'(s);
                s = ddx * xs + ddy * yd; v[1] = s < 0 ? 64'(-s) : 64'(s);
                s = ddx * xs + ddy * ys; v[2] = s < 0 ? 64'(-s) : 64'(s);
                s = ddx * xd + ddy * ys; v[3] = s < 0 ? 64'(-s) : 64'(s);
                // running choice: at or above the running high (fmin) moves it, else the low (fmax)
                fmin = v[0];
                fmax = v[0];
                for (int i = 1; i < 4; i++) begin
                    if (v[i] >= fmin) fmin = v[i];
                    else fmax = v[i];
                end
                lo = scale_tol(wide_t'(fmax), 1);
                hi = scale_tol(wide_t'(fmin), 1);
            end else begin
                distant_items++;
                nz = longint'($signed(g.box_min_z));
                xz = longint'($signed(g.box_max_z));
                if (ez < nz) hmin_u = sq64(ez - nz);
                else if (ez > xz) hmin_u = sq64(ez - xz);
                else hmin_u = 0;
                hmax_u = sq64(ez - nz);
                t = sq64(ez - xz);
                if (t > hmax_u) hmax_u = t;
                hmin = wide_t'(hmin_u);
                rmin = 0;
                rmax = 0;
                axis_dist(ex, longint'($signed(g.box_min_x)), longint'($signed(g.box_max_x)),
                          rmin, rmax);
                axis_dist(ey, longint'($signed(g.box_min_y)), longint'($signed(g.box_max_y)),
                          rmin, rmax);
                c1 = ratio_thresh(rmin, wide_t'(hmax_u));
                c2 = ratio_thresh(rmax, wide_t'(hmax_u));
                hi = c1 > c2 ? c1 : c2;
                if (rmin >= hmin) lo = ratio_thresh(rmin, hmin);
                else if (rmax <= hmin) lo = ratio_thresh(rmax, hmin);
                else lo = hmin_u == 0 ? 64'd0 : scale_tol(hmin * 4, 1);
            end
        endfunction

        function void note_block(geom_t g);
            bit [63:0] lo, hi;
            predict(g, lo, hi);
            exp_low.push_back(lo);
            exp_high.push_back(hi);
        endfunction

        function void flag(string what, bit [63:0] e, bit [63:0] a);
            errors++;
            if (errors <= 10)
                $display("%0t: %s expected %h got %h", $time, what, e, a);
        endfunction

        function void check_result(bit [63:0] lo, bit [63:0] hi);
            bit [63:0] el, eh;
            if (exp_low.size() == 0) begin
                flag("unexpected transfer, delta_low", 64'd0, lo);
                return;
            end
            el = exp_low.pop_front();
            eh = exp_high.pop_front();
            checked++;
            if (lo !== el) flag("delta_low", el, lo);
            if (hi !== eh) flag("delta_high", eh, hi);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    geom_t       blk = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [63:0] m_delta_low, m_delta_high;
    bit          calm = 1'b0;
    int          idle_cycles = 0;

    delta_scoreboard sb = new();

    terrain_lod_delta_interval_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_box_min_x(blk.box_min_x), .s_box_min_y(blk.box_min_y),
        .s_box_min_z(blk.box_min_z), .s_box_max_x(blk.box_max_x),
        .s_box_max_y(blk.box_max_y), .s_box_max_z(blk.box_max_z),
        .s_block_loc_x(blk.block_loc_x), .s_block_loc_y(blk.block_loc_y),
        .s_block_stride(blk.block_stride),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_delta_low(m_delta_low), .m_delta_high(m_delta_high)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver stalls
    always @(negedge aclk) m_ready <= calm || ($urandom_range(0, 99) >= 11);

    // result transfers
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_result(m_delta_low, m_delta_high);

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic cfg_write(reg_index_e idx, bit [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * 4); pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic cfg_all(bit cl, bit [31:0] tol, bit [31:0] ex, bit [31:0] ey,
                           bit [31:0] ez, int dx, int dy, bit [31:0] grid);
        cfg_write(REG_ASSUME_CLOSE, {31'd0, cl});
        cfg_write(REG_TOLERANCE, tol);
        cfg_write(REG_EYE_X, ex);
        cfg_write(REG_EYE_Y, ey);
        cfg_write(REG_EYE_Z, ez);
        cfg_write(REG_VIEW_DIR_X, 32'(dx));
        cfg_write(REG_VIEW_DIR_Y, 32'(dy));
        cfg_write(REG_GRID_SPACING, grid);
    endtask

    // random idle gaps before about 5 items in 100, except in the calm phase
    task automatic send_block(geom_t g);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 99) < 5) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
        blk <= g;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_block(g);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.exp_low.size() != 0) @(posedge aclk);
    endtask

    function automatic bit [31:0] rnd_coord(bit full);
        if (full) return $urandom;
        return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endfunction

    function automatic bit [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return rnd_coord(0);
        endcase
    endfunction

    function automatic int rnd_dir();
        case ($urandom_range(0, 5))
            0: return -65536;
            1: return 65536;
            default: return int'($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    function automatic geom_t rnd_block();
        geom_t g;
        bit    full;
        int    c, h;
        full = $urandom_range(0, 3) == 0;
        if (full) begin
            g.box_min_x = $urandom; g.box_min_y = $urandom; g.box_min_z = $urandom;
            g.box_max_x = $urandom; g.box_max_y = $urandom; g.box_max_z = $urandom;
        end else begin
            // mostly well-formed boxes around a random centre
            c = $signed(rnd_coord(0)); h = $urandom_range(0, 2 ** 19);
            g.box_min_x = c - h; g.box_max_x = c + h;
            c = $signed(rnd_coord(0)); h = $urandom_range(0, 2 ** 19);
            g.box_min_y = c - h; g.box_max_y = c + h;
            c = $signed(rnd_coord(0)); h = $urandom_range(0, 2 ** 18);
            g.box_min_z = c - h; g.box_max_z = c + h;
            if ($urandom_range(0, 19) == 0) g.box_min_z = g.box_max_z + 5;
        end
        g.block_loc_x = rnd_coord(full);
        g.block_loc_y = rnd_coord(full);
        if ($urandom_range(0, 4) == 0) g.block_stride = 8'($urandom);
        else g.block_stride = 8'(1 << $urandom_range(0, 7));
        return g;
    endfunction

    function automatic geom_t mk_box(int nx, int ny, int nz, int xx, int xy, int xz);
        geom_t g;
        g = '0;
        g.box_min_x = nx; g.box_min_y = ny; g.box_min_z = nz;
        g.box_max_x = xx; g.box_max_y = xy; g.box_max_z = xz;
        g.block_stride = 8'd1;
        return g;
    endfunction

    function automatic geom_t mk_loc(int lx, int ly, int stride);
        geom_t g;
        g = '0;
        g.block_loc_x = lx; g.block_loc_y = ly; g.block_stride = 8'(stride);
        return g;
    endfunction

    initial begin
        int n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero tolerance after reset
        repeat (3) send_block(rnd_block());
        drain();

        // distant mode corner cases
        cfg_all(1'b0, 32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000);
        send_block(mk_box(0, 0, 0, 0, 0, 0));
        send_block(mk_box(-65536, -65536, 131072, 65536, 65536, 196608));
        send_block(mk_box(-65536, -65536, -65536, 65536, 65536, 65536));
        send_block(mk_box(131072, 196608, -262144, 262144, 327680, -131072));
        send_block(mk_box(-2147483648, -2147483648, -2147483648,
                          2147483647, 2147483647, 2147483647));
        send_block(mk_box(65536, 65536, 65536, -65536, -65536, -65536));
        send_block(mk_box(2147483647, 2147483647, 2147483647,
                          2147483647, 2147483647, 2147483647));
        drain();

        // close mode, strides in and out of range
        cfg_all(1'b1, 32'h0001_0000, 32'h0005_0000, 32'h0003_0000, 0,
                65536, -65536, 32'h0001_0000);
        send_block(mk_loc(0, 0, 0));
        send_block(mk_loc(65536, -65536, 1));
        send_block(mk_loc(2147483647, -2147483648, 128));
        send_block(mk_loc(-2147483648, 2147483647, 255));
        send_block(mk_loc(327680, 196608, 3));
        send_block(mk_loc(0, 0, 129));
        drain();

        // register extremes in both modes
        cfg_all(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                -65536, 65536, 32'hFFFF_FFFF);
        repeat (3) send_block(rnd_block());
        drain();
        cfg_write(REG_ASSUME_CLOSE, 32'd0);
        cfg_write(REG_GRID_SPACING, 32'd0);
        repeat (3) send_block(rnd_block());
        drain();

        // random phases
        for (int p = 0; p < 10; p++) begin
            cfg_all(1'($urandom_range(0, 1)),
                    $urandom_range(0, 9) == 0 ? 32'd0 :
                    $urandom_range(0, 4) == 0 ? $urandom :
                    $urandom_range(0, 4) == 0 ? 32'hFFFF_FFFF :
                    32'($urandom_range(1, 32'h0004_0000)),
                    rnd_word(), rnd_word(), rnd_word(), rnd_dir(), rnd_dir(),
                    $urandom_range(0, 4) == 0 ? $urandom :
                    32'($urandom_range(0, 32'h0004_0000)));
            calm = (p == 3);
            n = 163;
            for (int i = 0; i < n; i++) begin
                if (p == 5 && i == 80) drain();
                send_block(rnd_block());
            end
            drain();
        end
        calm = 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("checked %0d intervals: %0d distant, %0d close, rest zero tolerance",
                 sb.checked, sb.distant_items, sb.close_items);
        $display("%0d mismatches over reset defaults, extremes and 10 random settings",
                 sb.errors);
        if (sb.errors == 0 && sb.exp_low.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
